[rtl/slcan_lr_pkg.sv]
package slcan_lr_pkg;

    // ASCII codes the parser keys on
    localparam logic [7:0] CHAR_T    = 8'h74;
    localparam logic [7:0] CHAR_O    = 8'h4F;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    // Frame layout: 't', three ID digits, one DLC digit
    localparam logic [4:0] MIN_SPAN      = 5'd5;
    localparam logic [4:0] POS_SAT       = 5'd31;
    localparam logic [4:0] POS_ID_FIRST  = 5'd1;
    localparam logic [4:0] POS_ID_LAST   = 5'd3;
    localparam logic [4:0] POS_DLC       = 5'd4;
    localparam logic [4:0] MIN_FRAME_RST = 5'd21;

    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_OPEN   = 2'd2,
        KIND_CLOSE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REASON_NONE    = 3'd0,
        REASON_NO_T    = 3'd1,
        REASON_SHORT   = 3'd2,
        REASON_BAD_DLC = 3'd3,
        REASON_BAD_HEX = 3'd4
    } reason_t;

    // One received byte after classification
    typedef struct packed {
        logic       is_cr;
        logic       is_t;
        kind_t      kind;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       dlc_ok;
        logic [3:0] dlc_val;
    } char_item_t;

    // Hex digit decode: bit 4 flags a valid digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[rtl/slcan_lr_front.sv]
module slcan_lr_front #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,
    output logic                     push_valid,
    input  logic                     push_ready,
    output slcan_lr_pkg::char_item_t push_item
);

    logic [4:0] hex_dec;
    logic [7:0] dlc_diff;

    // Classify the incoming byte in the same cycle it is offered
    always_comb begin
        hex_dec  = slcan_lr_pkg::hex_decode(s_rx_byte);
        dlc_diff = s_rx_byte - slcan_lr_pkg::CHAR_ZERO;

        push_item.is_cr   = (s_rx_byte == slcan_lr_pkg::CHAR_CR);
        push_item.is_t    = (s_rx_byte == slcan_lr_pkg::CHAR_T);
        push_item.hex_ok  = hex_dec[4];
        push_item.hex_val = hex_dec[3:0];
        push_item.dlc_ok  = (dlc_diff <= 8'(MAX_DATA_BYTES));
        push_item.dlc_val = dlc_diff[3:0];

        if (s_rx_byte == slcan_lr_pkg::CHAR_T) begin
            push_item.kind = slcan_lr_pkg::KIND_STATUS;
        end else if (s_rx_byte == slcan_lr_pkg::CHAR_O) begin
            push_item.kind = slcan_lr_pkg::KIND_OPEN;
        end else if (s_rx_byte == slcan_lr_pkg::CHAR_C) begin
            push_item.kind = slcan_lr_pkg::KIND_CLOSE;
        end else begin
            push_item.kind = slcan_lr_pkg::KIND_OTHER;
        end
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

[rtl/slcan_lr_fifo.sv]
module slcan_lr_fifo (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push_valid,
    output logic                     push_ready,
    input  slcan_lr_pkg::char_item_t push_item,
    output logic                     pop_valid,
    input  logic                     pop_ready,
    output slcan_lr_pkg::char_item_t pop_item
);

    // Two-entry queue between classifier and parser
    slcan_lr_pkg::char_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push_fire, pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push_fire ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 2'd1;
        end else if (!push_fire && pop_fire) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/slcan_lr_back.sv]
module slcan_lr_back #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [4:0]               min_frame_chars,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  slcan_lr_pkg::char_item_t pop_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_frame_valid,
    output logic [11:0]              m_can_id,
    output logic [3:0]               m_dlc,
    output logic [63:0]              m_payload,
    output logic [1:0]               m_line_kind,
    output logic [2:0]               m_reject_reason,
    output logic                     m_channel_open
);

    localparam int DATA_W  = 8 * MAX_DATA_BYTES;
    localparam int NIBBLES = 2 * MAX_DATA_BYTES;

    // Line parse state
    logic                line_start_reg, line_start_next;
    slcan_lr_pkg::kind_t kind_reg, kind_next;
    logic                seen_t_reg, seen_t_next;
    logic [4:0]          pos_reg, pos_next;
    logic [11:0]         id_reg, id_next;
    logic [3:0]          dlc_reg, dlc_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic                hex_err_reg, hex_err_next;
    logic                dlc_err_reg, dlc_err_next;
    logic                chan_reg, chan_next;

    // Result register
    logic                    m_valid_reg, m_valid_next;
    logic                    out_frame_valid_reg, out_frame_valid_next;
    logic [11:0]             out_can_id_reg, out_can_id_next;
    logic [3:0]              out_dlc_reg, out_dlc_next;
    logic [63:0]             out_payload_reg, out_payload_next;
    slcan_lr_pkg::kind_t     out_kind_reg, out_kind_next;
    slcan_lr_pkg::reason_t   out_reason_reg, out_reason_next;
    logic                    out_chan_reg, out_chan_next;

    logic                  out_free, pop_fire, cr_fire;
    logic [4:0]            data_off, nib_sel, need;
    logic [3:0]            byte_idx;
    logic                  in_data;
    logic [5:0]            span_need;
    slcan_lr_pkg::reason_t reason;

    // A line end needs the result register free; other bytes never wait
    assign out_free  = !m_valid_reg || m_ready;
    assign pop_ready = !pop_item.is_cr || out_free;
    assign pop_fire  = pop_valid && pop_ready;
    assign cr_fire   = pop_fire && pop_item.is_cr;

    // Data digit addressing
    assign data_off = pos_reg - slcan_lr_pkg::MIN_SPAN;
    assign byte_idx = data_off[4:1];
    assign nib_sel  = {byte_idx, ~data_off[0]};
    assign in_data  = (pos_reg >= slcan_lr_pkg::MIN_SPAN) && !dlc_err_reg
                      && (byte_idx < dlc_reg);

    // Reject reason, first applicable wins
    always_comb begin
        need      = (min_frame_chars < slcan_lr_pkg::MIN_SPAN) ? slcan_lr_pkg::MIN_SPAN
                                                               : min_frame_chars;
        span_need = 6'(slcan_lr_pkg::MIN_SPAN) + {1'b0, dlc_reg, 1'b0};
        if (!seen_t_reg) begin
            reason = slcan_lr_pkg::REASON_NO_T;
        end else if (pos_reg < need) begin
            reason = slcan_lr_pkg::REASON_SHORT;
        end else if (dlc_err_reg) begin
            reason = slcan_lr_pkg::REASON_BAD_DLC;
        end else if ({1'b0, pos_reg} < span_need) begin
            reason = slcan_lr_pkg::REASON_SHORT;
        end else if (hex_err_reg) begin
            reason = slcan_lr_pkg::REASON_BAD_HEX;
        end else begin
            reason = slcan_lr_pkg::REASON_NONE;
        end
    end

    // Per-byte state update
    always_comb begin
        line_start_next = line_start_reg;
        kind_next       = kind_reg;
        seen_t_next     = seen_t_reg;
        pos_next        = pos_reg;
        id_next         = id_reg;
        dlc_next        = dlc_reg;
        data_next       = data_reg;
        hex_err_next    = hex_err_reg;
        dlc_err_next    = dlc_err_reg;
        chan_next       = chan_reg;

        m_valid_next         = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        out_frame_valid_next = out_frame_valid_reg;
        out_can_id_next      = out_can_id_reg;
        out_dlc_next         = out_dlc_reg;
        out_payload_next     = out_payload_reg;
        out_kind_next        = out_kind_reg;
        out_reason_next      = out_reason_reg;
        out_chan_next        = out_chan_reg;

        if (pop_fire && !pop_item.is_cr) begin
            if (line_start_reg) begin
                line_start_next = 1'b0;
                kind_next       = pop_item.kind;
            end
            if (!seen_t_reg) begin
                if (pop_item.is_t) begin
                    seen_t_next = 1'b1;
                    pos_next    = slcan_lr_pkg::POS_ID_FIRST;
                end
            end else begin
                if (pos_reg >= slcan_lr_pkg::POS_ID_FIRST
                        && pos_reg <= slcan_lr_pkg::POS_ID_LAST) begin
                    if (!pop_item.hex_ok) begin
                        hex_err_next = 1'b1;
                    end else begin
                        id_next = {id_reg[7:0], pop_item.hex_val};
                    end
                end else if (pos_reg == slcan_lr_pkg::POS_DLC) begin
                    if (!pop_item.dlc_ok) begin
                        dlc_err_next = 1'b1;
                    end else begin
                        dlc_next = pop_item.dlc_val;
                    end
                end else if (in_data) begin
                    if (!pop_item.hex_ok) begin
                        hex_err_next = 1'b1;
                    end else begin
                        for (int n = 0; n < NIBBLES; n++) begin
                            if (nib_sel == 5'(n)) begin
                                data_next[4*n +: 4] = data_reg[4*n +: 4] | pop_item.hex_val;
                            end
                        end
                    end
                end
                if (pos_reg != slcan_lr_pkg::POS_SAT) begin
                    pos_next = pos_reg + 5'd1;
                end
            end
        end

        // Line end: apply the command, load the result, start a new line
        if (cr_fire) begin
            if (kind_reg == slcan_lr_pkg::KIND_OPEN) begin
                chan_next = 1'b1;
            end else if (kind_reg == slcan_lr_pkg::KIND_CLOSE) begin
                chan_next = 1'b0;
            end

            m_valid_next         = 1'b1;
            out_frame_valid_next = (reason == slcan_lr_pkg::REASON_NONE);
            out_can_id_next      = (reason == slcan_lr_pkg::REASON_NONE) ? id_reg : 12'd0;
            out_dlc_next         = (reason == slcan_lr_pkg::REASON_NONE) ? dlc_reg : 4'd0;
            out_payload_next     = (reason == slcan_lr_pkg::REASON_NONE) ? 64'(data_reg)
                                                                         : 64'd0;
            out_kind_next        = kind_reg;
            out_reason_next      = reason;
            out_chan_next        = chan_next;

            line_start_next = 1'b1;
            kind_next       = slcan_lr_pkg::KIND_OTHER;
            seen_t_next     = 1'b0;
            pos_next        = 5'd0;
            id_next         = 12'd0;
            dlc_next        = 4'd0;
            data_next       = '0;
            hex_err_next    = 1'b0;
            dlc_err_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_start_reg <= 1'b1;
            kind_reg       <= slcan_lr_pkg::KIND_OTHER;
            seen_t_reg     <= 1'b0;
            pos_reg        <= 5'd0;
            id_reg         <= 12'd0;
            dlc_reg        <= 4'd0;
            data_reg       <= '0;
            hex_err_reg    <= 1'b0;
            dlc_err_reg    <= 1'b0;
            chan_reg       <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            line_start_reg <= line_start_next;
            kind_reg       <= kind_next;
            seen_t_reg     <= seen_t_next;
            pos_reg        <= pos_next;
            id_reg         <= id_next;
            dlc_reg        <= dlc_next;
            data_reg       <= data_next;
            hex_err_reg    <= hex_err_next;
            dlc_err_reg    <= dlc_err_next;
            chan_reg       <= chan_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        out_frame_valid_reg <= out_frame_valid_next;
        out_can_id_reg      <= out_can_id_next;
        out_dlc_reg         <= out_dlc_next;
        out_payload_reg     <= out_payload_next;
        out_kind_reg        <= out_kind_next;
        out_reason_reg      <= out_reason_next;
        out_chan_reg        <= out_chan_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_valid   = out_frame_valid_reg;
    assign m_can_id        = out_can_id_reg;
    assign m_dlc           = out_dlc_reg;
    assign m_payload       = out_payload_reg;
    assign m_line_kind     = out_kind_reg;
    assign m_reject_reason = out_reason_reg;
    assign m_channel_open  = out_chan_reg;

`ifndef SYNTH
    // An accepted frame carries no reject reason and a legal length
    a_valid_no_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_frame_valid_reg |->
            out_reason_reg == slcan_lr_pkg::REASON_NONE
            && out_dlc_reg <= 4'(MAX_DATA_BYTES))
        else $error("accepted frame with reject reason or oversize dlc");

    // A rejected line shows zeroed frame fields
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !out_frame_valid_reg |->
            out_can_id_reg == 12'd0 && out_dlc_reg == 4'd0 && out_payload_reg == 64'd0)
        else $error("rejected line with nonzero frame fields");

    // Frame position only advances once a 't' was seen
    a_pos_needs_t: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_t_reg |-> pos_reg == 5'd0)
        else $error("frame position moved without a 't'");

    // Every consumed line end produces a pending result
    a_cr_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        cr_fire |=> m_valid_reg && line_start_reg)
        else $error("line end did not load a result");
`endif

endmodule

[rtl/slcan_line_receiver_core.sv]
// Channel   Handshake             Payload
// s_        s_valid / s_ready     s_rx_byte (8)
// m_        m_valid / m_ready     frame_valid, can_id, dlc, payload, line_kind,
//                                 reject_reason, channel_open
// cfg_      cfg_valid / cfg_ready cfg_data (5) = min_frame_chars
//
// One byte per cycle unless a carriage return waits on the output register:
// a classifier feeds a two-entry queue, the parser takes one byte per cycle.
// A carriage return passes the queue, then loads the output register.
// A carriage return waits in the queue only while the output register holds
// a result that has not been taken; s_ready drops once one more byte has
// queued behind that waiting carriage return.
// Reset (aresetn low, synchronous) clears the line state, opens the channel
// flag and sets min_frame_chars to 21. cfg_ready is always high.
module slcan_line_receiver_core #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_valid,
    output logic [11:0] m_can_id,
    output logic [3:0]  m_dlc,
    output logic [63:0] m_payload,
    output logic [1:0]  m_line_kind,
    output logic [2:0]  m_reject_reason,
    output logic        m_channel_open,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    logic                     push_valid, push_ready;
    slcan_lr_pkg::char_item_t push_item;
    logic                     pop_valid, pop_ready;
    slcan_lr_pkg::char_item_t pop_item;
    logic [4:0]               min_frame_reg;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_frame_reg <= slcan_lr_pkg::MIN_FRAME_RST;
        end else if (cfg_valid && cfg_ready) begin
            min_frame_reg <= cfg_data;
        end
    end

    slcan_lr_front #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    slcan_lr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    slcan_lr_back #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .min_frame_chars (min_frame_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_item        (pop_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_valid   (m_frame_valid),
        .m_can_id        (m_can_id),
        .m_dlc           (m_dlc),
        .m_payload       (m_payload),
        .m_line_kind     (m_line_kind),
        .m_reject_reason (m_reject_reason),
        .m_channel_open  (m_channel_open)
    );

endmodule

[test/tb_slcan_line_receiver_core.sv]
`timescale 1ns / 1ps

module tb_slcan_line_receiver_core;

    localparam int MAX_DATA_BYTES = 8;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BYTES   = 1080;
    localparam int RANDOM_PHASES  = 6;

    // One line's outcome as seen on the result channel
    typedef struct {
        logic                  frame_valid;
        logic [11:0]           can_id;
        logic [3:0]            dlc;
        logic [63:0]           payload;
        slcan_lr_pkg::kind_t   line_kind;
        slcan_lr_pkg::reason_t reject_reason;
        logic                  channel_open;
    } line_result_t;

    // Line parser model plus the queue of line results still owed by the block
    class line_scoreboard;
        logic [4:0]          min_chars;
        logic                at_line_start;
        slcan_lr_pkg::kind_t first_kind;
        logic                seen_t;
        logic [4:0]          pos;
        logic [11:0]         id_acc;
        logic [3:0]          dlc_q;
        logic [63:0]         data_acc;
        logic                hex_bad;
        logic                dlc_bad;
        logic                chan_open;
        line_result_t        due_results[$];
        int                  fail_count;

        function new();
            min_chars  = slcan_lr_pkg::MIN_FRAME_RST;
            chan_open  = 1'b1;
            fail_count = 0;
            clear_line();
        endfunction

        function void clear_line();
            at_line_start = 1'b1;
            first_kind    = slcan_lr_pkg::KIND_OTHER;
            seen_t        = 1'b0;
            pos           = '0;
            id_acc        = '0;
            dlc_q         = '0;
            data_acc      = '0;
            hex_bad       = 1'b0;
            dlc_bad       = 1'b0;
        endfunction

        // bit 4 set when c is a hex digit, value in bits 3:0
        function logic [4:0] hex_nibble(logic [7:0] c);
            logic [7:0] v;
            v = 8'hFF;
            if (c inside {[8'h30:8'h39]}) v = c - 8'h30;
            else if (c inside {[8'h41:8'h46]}) v = c - 8'h41 + 8'd10;
            else if (c inside {[8'h61:8'h66]}) v = c - 8'h61 + 8'd10;
            return (v == 8'hFF) ? 5'd0 : {1'b1, v[3:0]};
        endfunction

        function void set_min_chars(logic [4:0] v);
            min_chars = v;
        endfunction

        // Advance the parser by one accepted byte; a CR queues one line result
        function void note_byte(logic [7:0] c);
            logic [4:0]            h;
            logic [7:0]            dv;
            int                    p;
            int                    idx;
            int                    need;
            slcan_lr_pkg::reason_t why;
            line_result_t          r;
            if (c != slcan_lr_pkg::CHAR_CR) begin
                if (at_line_start) begin
                    at_line_start = 1'b0;
                    first_kind = (c == slcan_lr_pkg::CHAR_T) ? slcan_lr_pkg::KIND_STATUS :
                                 (c == slcan_lr_pkg::CHAR_O) ? slcan_lr_pkg::KIND_OPEN :
                                 (c == slcan_lr_pkg::CHAR_C) ? slcan_lr_pkg::KIND_CLOSE :
                                                               slcan_lr_pkg::KIND_OTHER;
                end
                if (!seen_t) begin
                    if (c == slcan_lr_pkg::CHAR_T) begin
                        seen_t = 1'b1;
                        pos    = 5'd1;
                    end
                end else begin
                    h = hex_nibble(c);
                    p = pos;
                    if (p >= 1 && p <= 3) begin
                        if (!h[4]) hex_bad = 1'b1;
                        else id_acc = {id_acc[7:0], h[3:0]};
                    end else if (p == 4) begin
                        dv = c - slcan_lr_pkg::CHAR_ZERO;
                        if (dv > MAX_DATA_BYTES) dlc_bad = 1'b1;
                        else dlc_q = dv[3:0];
                    end else if (p >= 5 && !dlc_bad) begin
                        idx = (p - 5) >> 1;
                        if (idx < int'(dlc_q)) begin
                            if (!h[4]) hex_bad = 1'b1;
                            else data_acc[idx * 8 + (((p - 5) % 2 == 1) ? 0 : 4) +: 4] = h[3:0];
                        end
                    end
                    if (pos < slcan_lr_pkg::POS_SAT) pos = pos + 5'd1;
                end
                return;
            end

            // carriage return: channel command takes effect, then the verdict
            if (first_kind == slcan_lr_pkg::KIND_OPEN) chan_open = 1'b1;
            else if (first_kind == slcan_lr_pkg::KIND_CLOSE) chan_open = 1'b0;
            need = (min_chars < slcan_lr_pkg::MIN_SPAN) ? int'(slcan_lr_pkg::MIN_SPAN)
                                                        : int'(min_chars);
            p    = pos;
            if (!seen_t) why = slcan_lr_pkg::REASON_NO_T;
            else if (p < need) why = slcan_lr_pkg::REASON_SHORT;
            else if (dlc_bad) why = slcan_lr_pkg::REASON_BAD_DLC;
            else if (p < 5 + 2 * int'(dlc_q)) why = slcan_lr_pkg::REASON_SHORT;
            else if (hex_bad) why = slcan_lr_pkg::REASON_BAD_HEX;
            else why = slcan_lr_pkg::REASON_NONE;

            r.frame_valid   = (why == slcan_lr_pkg::REASON_NONE);
            r.can_id        = r.frame_valid ? id_acc : '0;
            r.dlc           = r.frame_valid ? dlc_q : '0;
            r.payload       = r.frame_valid ? data_acc : '0;
            r.line_kind     = first_kind;
            r.reject_reason = why;
            r.channel_open  = chan_open;
            due_results.push_back(r);
            clear_line();
        endfunction

        task report_error(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            fail_count++;
        endtask

        task cmp_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_error($sformatf("%s got %0h, expected %0h", name, got, want));
        endtask

        task check_line_result(line_result_t got);
            line_result_t want;
            if (due_results.size() == 0) begin
                report_error("line result with nothing expected");
                return;
            end
            want = due_results.pop_front();
            cmp_field("frame_valid", got.frame_valid, want.frame_valid);
            cmp_field("can_id", got.can_id, want.can_id);
            cmp_field("dlc", got.dlc, want.dlc);
            cmp_field("payload", got.payload, want.payload);
            cmp_field("line_kind", got.line_kind, want.line_kind);
            cmp_field("reject_reason", got.reject_reason, want.reject_reason);
            cmp_field("channel_open", got.channel_open, want.channel_open);
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_frame_valid;
    logic [11:0] m_can_id;
    logic [3:0]  m_dlc;
    logic [63:0] m_payload;
    logic [1:0]  m_line_kind;
    logic [2:0]  m_reject_reason;
    logic        m_channel_open;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;

    line_scoreboard sb;
    logic [7:0]     line_buf[$];
    bit             calm = 1'b0;
    int             n_sent = 0;

    slcan_line_receiver_core #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_valid  (m_frame_valid),
        .m_can_id       (m_can_id),
        .m_dlc          (m_dlc),
        .m_payload      (m_payload),
        .m_line_kind    (m_line_kind),
        .m_reject_reason(m_reject_reason),
        .m_channel_open (m_channel_open),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result channel backpressure
    always @(posedge aclk) begin
        if (!calm && $urandom_range(99) < 13) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Transfer monitor: results are checked before the same edge's byte is noted
    always @(posedge aclk) begin
        line_result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.frame_valid   = m_frame_valid;
                got.can_id        = m_can_id;
                got.dlc           = m_dlc;
                got.payload       = m_payload;
                got.line_kind     = slcan_lr_pkg::kind_t'(m_line_kind);
                got.reject_reason = slcan_lr_pkg::reason_t'(m_reject_reason);
                got.channel_open  = m_channel_open;
                sb.check_line_result(got);
            end
            if (s_valid && s_ready) sb.note_byte(s_rx_byte);
            if (cfg_valid && cfg_ready) sb.set_min_chars(cfg_data);
        end
    end

    // Byte transfer, optionally after idling s_valid; returns at the accepting edge
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic send_buf();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        send_byte(slcan_lr_pkg::CHAR_CR);
        line_buf.delete();
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        put_str(s);
        send_buf();
    endtask

    // Stop sending and wait until every owed line result has come back
    task automatic settle();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_min(input logic [4:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] any_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == slcan_lr_pkg::CHAR_CR) b = 8'h0C;
        return b;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10) return 8'(8'h30 + v);
        return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    // Mostly a hex digit, now and then garbage
    function automatic logic [7:0] maybe_hex();
        return ($urandom_range(29) == 0) ? any_byte() : hex_char();
    endfunction

    // Frame line with random content and occasional damage
    task automatic build_frame();
        int dlc_n;
        line_buf.delete();
        case ($urandom_range(9))
            0: line_buf.push_back(slcan_lr_pkg::CHAR_O);
            1: line_buf.push_back(slcan_lr_pkg::CHAR_C);
            2: repeat ($urandom_range(3, 1)) line_buf.push_back(any_byte());
            default: ;
        endcase
        line_buf.push_back(slcan_lr_pkg::CHAR_T);
        repeat (3) line_buf.push_back(maybe_hex());
        dlc_n = $urandom_range(MAX_DATA_BYTES);
        if ($urandom_range(19) == 0) line_buf.push_back(any_byte());
        else line_buf.push_back(8'(slcan_lr_pkg::CHAR_ZERO + dlc_n));
        repeat (2 * dlc_n) line_buf.push_back(maybe_hex());
        // truncated data digits
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(2 * dlc_n + 1, 1)) void'(line_buf.pop_back());
        // trailing junk
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(12, 1)) line_buf.push_back(any_byte());
    endtask

    // Commands, empty lines and random byte soup
    task automatic build_noise();
        line_buf.delete();
        case ($urandom_range(4))
            0: line_buf.push_back(slcan_lr_pkg::CHAR_O);
            1: line_buf.push_back(slcan_lr_pkg::CHAR_C);
            2: line_buf.push_back(slcan_lr_pkg::CHAR_T);
            3: ;
            default: repeat ($urandom_range(30, 1)) line_buf.push_back(any_byte());
        endcase
    endtask

    initial begin
        int         ph;
        logic [4:0] setting;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset threshold of 21: full-length frames, commands, empty line
        send_text("t12380123456789abcDEF");
        send_text("t7FF70011223344556699");
        send_text("t123");
        send_text("");
        send_text("C");
        send_text("t");
        send_text("O");

        settle();
        write_min(5'd5);
        send_text("tFFF0");
        send_text("tabc2DeAd");
        send_text("t0009");
        send_text("t000/");
        send_text("t0003AB");
        send_text("t0G0100");
        send_text("t00012Z");
        send_text("xyt1231AA");
        send_text("Ct1230");
        send_text("t1t31AB");
        line_buf.delete();
        line_buf.push_back(8'h00);
        put_str("t1230");
        line_buf.push_back(8'hFF);
        send_buf();

        // threshold below the fixed floor
        settle();
        write_min(5'd0);
        send_text("t0000");
        send_text("t000");

        // top threshold: the span counter saturates
        settle();
        write_min(5'd31);
        send_text("t5A58fedcba9876543210xxxxxxxxxxxxxxxxxxxx");
        send_text("t5A58fedcba9876543210xxxxxxxxx");

        // random lines, one threshold per phase; one phase runs without idling
        n_sent = 0;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0: setting = 5'd21;
                1: setting = 5'd5;
                2: setting = 5'd13;
                3: setting = 5'd4;
                4: setting = 5'd31;
                default: setting = 5'($urandom_range(31));
            endcase
            write_min(setting);
            calm = (ph == 2);
            while (n_sent < RANDOM_BYTES * (ph + 1) / RANDOM_PHASES) begin
                if ($urandom_range(99) < 75) build_frame();
                else build_noise();
                send_buf();
            end
        end
        calm = 1'b0;

        settle();
        if (sb.due_results.size() != 0) sb.report_error("line results never arrived");
        if (sb.fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
